### hw/rtl/lpct_pkg.sv
// ----------------------------------------------------------------------------
// lpct_pkg: shared types and constants of the LRU page cache tag engine
// Entry count, field widths and the lookup summary passed between modules.
// ----------------------------------------------------------------------------
package lpct_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int SLOT_W      = $clog2(MAX_ENTRIES);
	localparam int OCC_W       = $clog2(MAX_ENTRIES + 1);
	localparam int PAGE_W      = 32;
	localparam int CAP_W       = 5;
	localparam int CAP_RESET   = 16;
	localparam int OUT_TDATA_W = 40;

	typedef logic [PAGE_W-1:0] page_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [SLOT_W-1:0] rank_t;
	typedef logic [OCC_W-1:0]  occ_t;
	typedef logic [CAP_W-1:0]  cap_t;

	// Result of one pass over the tag array
	typedef struct packed {
		logic  hit;
		slot_t hit_slot;
		slot_t lru_slot;
		slot_t free_slot;
	} lookup_t;

endpackage

### hw/rtl/lpct_lookup.sv
// ----------------------------------------------------------------------------
// lpct_lookup: parallel tag match and slot selection
// Compares the page against every valid tag and picks the hit slot, the least
// recent slot and the lowest free slot.
// ----------------------------------------------------------------------------
module lpct_lookup
	import lpct_pkg::*;
(
	input  page_t                  page,
	input  page_t                  tags [MAX_ENTRIES],
	input  logic [MAX_ENTRIES-1:0] valid,
	input  rank_t                  ranks [MAX_ENTRIES],
	input  occ_t                   occ,
	output lookup_t                lkp
);

	rank_t lru_rank;

	// the oldest valid entry carries rank occ - 1
	assign lru_rank = rank_t'(occ - occ_t'(1));

	always_comb begin
		lkp = '0;
		// scan from the top so the lowest-numbered slot wins
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (valid[i] && tags[i] == page) begin
				lkp.hit      = 1'b1;
				lkp.hit_slot = SLOT_W'(i);
			end
			if (valid[i] && ranks[i] == lru_rank) begin
				lkp.lru_slot = SLOT_W'(i);
			end
			if (!valid[i]) begin
				lkp.free_slot = SLOT_W'(i);
			end
		end
	end

endmodule

### hw/rtl/lru_page_cache_tags_core.sv
// ----------------------------------------------------------------------------
// lru_page_cache_tags_core: tag and replacement engine of an LRU page cache
// Fully associative, sixteen slots, least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   s_tvalid/s_tready/s_tdata carry one page index per beat. Each beat yields
//   exactly one result beat on m_tvalid/m_tready: the slot now holding the
//   page in m_tdata, the hit flag and the evicted flag in m_tuser, and the
//   evicted page index (zero on a hit or a fill into a free slot).
//   cfg_valid/cfg_ready/cfg_data write the capacity in use; write it only
//   while no beat is in flight. Zero acts as one, values above sixteen as
//   sixteen. Lowering it below the occupancy makes each later miss evict.
// Timing:
//   An input beat is held in the s1 register; the tag match, slot choice and
//   rank update run combinationally from there into the output register.
//   One beat per cycle is sustained while m_tready stays high; the limit is
//   the combinational pass over the sixteen registered tags and ranks.
// Reset and stall:
//   arst_n empties the cache and restores capacity sixteen; no sweep is
//   needed. When m_tready is low the result holds, the s1 beat waits and
//   s_tready drops once s1 is occupied.
// ----------------------------------------------------------------------------
module lru_page_cache_tags_core
	import lpct_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// input stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [PAGE_W-1:0]      s_tdata,    // [31:0] page_index
	// result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,    // [3:0] slot, [35:4] evicted_index, rest 0
	output logic [1:0]             m_tuser,    // [0] hit, [1] evicted_valid
	// configuration
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CAP_W-1:0]       cfg_data    // [4:0] capacity_in_use
);

	localparam int CMP_W = OCC_W + CAP_W;

	// configuration
	cap_t cap_q;

	// input stage
	logic  s1_valid_q;
	page_t page_s1;

	// cache state
	page_t                  tags_q  [MAX_ENTRIES];
	rank_t                  ranks_q [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] valid_q;
	occ_t                   occ_q;

	// result register
	logic  out_valid_q;
	logic  hit_q;
	slot_t slot_q;
	logic  ev_valid_q;
	page_t ev_index_q;

	// combinational pass
	lookup_t          lkp;
	logic             advance;
	logic             full;
	slot_t            sel_slot;
	logic [CMP_W-1:0] cap_eff;

	// Configuration is always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(CAP_RESET);
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	// Clamp the capacity into 1 .. MAX_ENTRIES
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CMP_W'(1);
		end else if (CMP_W'(cap_q) > CMP_W'(MAX_ENTRIES)) begin
			cap_eff = CMP_W'(MAX_ENTRIES);
		end else begin
			cap_eff = CMP_W'(cap_q);
		end
	end

	assign full = CMP_W'(occ_q) >= cap_eff;

	// Advance the s1 beat whenever the output register is free or draining
	assign advance  = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			page_s1 <= s_tdata;
		end
	end

	lpct_lookup u_lookup (
		.page  (page_s1),
		.tags  (tags_q),
		.valid (valid_q),
		.ranks (ranks_q),
		.occ   (occ_q),
		.lkp   (lkp)
	);

	// Hit slot, else the least recent when full, else the lowest free slot
	always_comb begin
		if (lkp.hit) begin
			sel_slot = lkp.hit_slot;
		end else if (full) begin
			sel_slot = lkp.lru_slot;
		end else begin
			sel_slot = lkp.free_slot;
		end
	end

	// Control state: valid bits, ranks and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				ranks_q[i] <= '0;
			end
		end else if (advance) begin
			if (!lkp.hit) begin
				valid_q[sel_slot] <= 1'b1;
				if (!full) begin
					occ_q <= occ_q + occ_t'(1);
				end
			end
			// Make the chosen slot most recent; age the ones ahead of it.
			// On a miss every other valid entry ages by one.
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (SLOT_W'(i) == sel_slot) begin
					ranks_q[i] <= '0;
				end else if (valid_q[i] && (!lkp.hit || ranks_q[i] < ranks_q[sel_slot])) begin
					ranks_q[i] <= ranks_q[i] + rank_t'(1);
				end
			end
		end
	end

	// Tags: written on a miss only, read only while valid
	always_ff @(posedge clk) begin
		if (advance && !lkp.hit) begin
			tags_q[sel_slot] <= page_s1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_q      <= lkp.hit;
			slot_q     <= sel_slot;
			ev_valid_q <= !lkp.hit && full;
			ev_index_q <= (!lkp.hit && full) ? tags_q[lkp.lru_slot] : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = {ev_valid_q, hit_q};
	assign m_tdata  = {(OUT_TDATA_W - PAGE_W - SLOT_W)'(0), ev_index_q, slot_q};

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	a_occ_matches_valid : assert property (@(posedge clk) disable iff (!arst_n)
		32'(occ_q) == $countones(valid_q))
		else $error("occupancy count disagrees with valid bits");

	a_occ_in_range : assert property (@(posedge clk) disable iff (!arst_n)
		32'(occ_q) <= MAX_ENTRIES)
		else $error("occupancy above entry count");

	a_evict_keeps_occ : assert property (@(posedge clk) disable iff (!arst_n)
		advance && !lkp.hit && full |=> $stable(occ_q))
		else $error("occupancy changed on an eviction");

	a_hit_no_evict : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && hit_q |-> !ev_valid_q && ev_index_q == '0)
		else $error("hit result reports an eviction");

	a_hold_when_stalled : assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && out_valid_q && !m_tready |=> s1_valid_q && $stable(page_s1))
		else $error("s1 beat lost while output stalled");

endmodule

### test/lru_page_cache_tags_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_cache_tags_core_checker: result predictor for the LRU tag engine
// Watches the request, result and capacity channels, keeps its own copy of
// the tag store and recency order, and compares every result beat with the
// oldest predicted answer.
// ----------------------------------------------------------------------------
module lru_page_cache_tags_core_checker
	import lpct_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [PAGE_W-1:0]      s_tdata,    // [31:0] page_index
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,    // [3:0] slot, [35:4] evicted_index, rest 0
	input  logic [1:0]             m_tuser,    // [0] hit, [1] evicted_valid
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CAP_W-1:0]       cfg_data,   // [4:0] capacity_in_use
	output int                     mismatches,
	output int                     pending
);

	typedef struct packed {
		logic  hit;
		slot_t slot;
		logic  evicted;
		page_t evicted_page;
	} cache_answer_t;

	page_t         tag_of    [MAX_ENTRIES];
	logic          slot_held [MAX_ENTRIES];
	rank_t         age_of    [MAX_ENTRIES];
	int            held_count;
	cap_t          capacity_reg;
	int            mismatch_total;
	cache_answer_t expected_answers [$];

	// Make slot s the most recent; held entries younger than limit age by one
	function automatic void make_recent(input int s, input int limit);
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (slot_held[i] && i != s && int'(age_of[i]) < limit)
				age_of[i] = age_of[i] + 1'b1;
		end
		age_of[s] = '0;
	endfunction

	function automatic cache_answer_t serve_page(input page_t page);
		int            eff;
		int            s;
		int            best;
		logic          found;
		cache_answer_t ans;
		eff   = (capacity_reg == 0) ? 1 :
			(int'(capacity_reg) > MAX_ENTRIES) ? MAX_ENTRIES : int'(capacity_reg);
		s     = 0;
		found = 1'b0;
		ans   = '0;
		for (int i = 0; i < MAX_ENTRIES && !found; i++) begin
			if (slot_held[i] && tag_of[i] == page) begin
				s     = i;
				found = 1'b1;
			end
		end
		if (found) begin
			make_recent(s, int'(age_of[s]));
		end else if (held_count >= eff) begin
			// evict the oldest held entry, lowest slot on a tie
			best = -1;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (slot_held[i] && int'(age_of[i]) > best) begin
					best = int'(age_of[i]);
					s    = i;
				end
			end
			ans.evicted      = 1'b1;
			ans.evicted_page = tag_of[s];
			tag_of[s]        = page;
			make_recent(s, int'(age_of[s]));
		end else begin
			for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
				if (!slot_held[i])
					s = i;
			end
			slot_held[s] = 1'b1;
			tag_of[s]    = page;
			age_of[s]    = '0;
			make_recent(s, MAX_ENTRIES + 1);
			held_count++;
		end
		ans.hit  = found;
		ans.slot = slot_t'(s);
		return ans;
	endfunction

	task automatic check_field(input string name, input logic [PAGE_W-1:0] want,
			input logic [PAGE_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		cache_answer_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				slot_held[i] = 1'b0;
				age_of[i]    = '0;
				tag_of[i]    = '0;
			end
			held_count     = 0;
			capacity_reg   = cap_t'(CAP_RESET);
			mismatch_total = 0;
			expected_answers.delete();
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				capacity_reg = cfg_data;
			if (m_tvalid && m_tready) begin
				if (expected_answers.size() == 0) begin
					$error("result beat with no request outstanding: tdata 0x%0h tuser 0x%0h",
						m_tdata, m_tuser);
					mismatch_total++;
				end else begin
					want = expected_answers.pop_front();
					check_field("hit", want.hit, m_tuser[0]);
					check_field("slot", want.slot, m_tdata[SLOT_W-1:0]);
					check_field("evicted_valid", want.evicted, m_tuser[1]);
					check_field("evicted_index", want.evicted_page, m_tdata[35:4]);
					check_field("tdata padding", '0, m_tdata[OUT_TDATA_W-1:36]);
				end
			end
			if (s_tvalid && s_tready)
				expected_answers.push_back(serve_page(s_tdata));
			mismatches <= mismatch_total;
			pending    <= expected_answers.size();
		end
	end

endmodule

### test/lru_page_cache_tags_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_cache_tags_core_test: testbench top of the LRU page cache tag engine
// Drives page lookups and capacity writes through a series of capacity
// settings, stalls both streams at random, and leaves the prediction and
// comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module lru_page_cache_tags_core_test
	import lpct_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on any channel
	localparam int LONG_HOLD      = 64;    // receiver back-pressure stretch
	localparam int PHASES         = 14;
	localparam int PHASE_ITEMS    = 80;
	localparam int TAIL_ITEMS     = 110;
	localparam int SETTLE_CYCLES  = 4;     // idle wait before each capacity write

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [PAGE_W-1:0]      s_tdata;    // [31:0] page_index
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;    // [3:0] slot, [35:4] evicted_index, rest 0
	logic [1:0]             m_tuser;    // [0] hit, [1] evicted_valid
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CAP_W-1:0]       cfg_data;   // [4:0] capacity_in_use

	int   mismatches;
	int   pending;
	int   stall_cycles;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   hold_requests;
	int   holds_done;
	bit   quiet_tail;

	page_t pool [MAX_ENTRIES + 4];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	lru_page_cache_tags_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	lru_page_cache_tags_core_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.mismatches(mismatches),
		.pending   (pending)
	);

	// Watchdog: end the run once no beat has moved on any channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("lru_page_cache_tags_core verification failed");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end else begin
			stall_cycles <= 0;
		end
	end

	// Result side: random ready bursts, plus one long hold on request so the
	// block backs up into its input stage while the sender keeps offering
	initial begin
		int n;
		m_tready   = 1'b0;
		holds_done = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (holds_done < hold_requests) begin
				holds_done++;
				m_tready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end
			if (!quiet_tail && $urandom_range(0, 99) < recv_idle_pct) begin
				n        = $urandom_range(1, 5);
				m_tready = 1'b0;
				repeat (n - 1) @(negedge clk);
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// Offer one page beat; start and end on a falling edge, valid left high so
	// back-to-back beats run at full rate
	task automatic offer_page(input page_t page);
		int n;
		if (!quiet_tail && $urandom_range(0, 99) < send_idle_pct) begin
			n        = $urandom_range(1, 5);
			s_tvalid = 1'b0;
			s_tdata  = $urandom;
			repeat (n) @(negedge clk);
		end
		s_tdata  = page;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Drop valid and hold off until every outstanding result has been taken
	task automatic drain_results();
		s_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// Write the capacity only with the block idle
	task automatic write_capacity(input cap_t value);
		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_data  = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		cap_t phase_caps [PHASES];
		int   idle_choices [3];
		int   eff;
		int   pool_size;
		int   items;
		page_t pick;

		phase_caps   = '{5'd1, 5'd2, 5'd3, 5'd5, 5'd8, 5'd12, 5'd16, 5'd0, 5'd17, 5'd31,
			5'd4, 5'd16, 5'd9, 5'd31};
		idle_choices = '{0, 10, 35};
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		quiet_tail    = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: extreme page indices and hits at reset capacity
		offer_page(32'h0000_0000);
		offer_page(32'hFFFF_FFFF);
		offer_page(32'h0000_0000);
		offer_page(32'h0000_0005);
		offer_page(32'hFFFF_FFFF);
		offer_page(32'h0000_0007);
		// capacity below occupancy: every miss evicts, occupancy holds
		write_capacity(5'd2);
		offer_page(32'h0000_0009);
		offer_page(32'h0000_0000);
		offer_page(32'h0000_0009);
		offer_page(32'h1234_5678);
		// capacity zero acts as one
		write_capacity(5'd0);
		offer_page(32'h0000_0001);
		offer_page(32'h0000_0001);
		offer_page(32'h0000_0002);
		// capacity above the entry count saturates; fill free slots again
		write_capacity(5'd31);
		offer_page(32'hAAAA_AAAA);
		offer_page(32'h5555_5555);
		offer_page(32'h0000_0002);
		offer_page(32'h8000_0000);

		// Random phases: a working set of the capacity to four pages above it gives
		// a mix of hits, fills and evictions; the rest are fresh pages
		for (int ph = 0; ph < PHASES; ph++) begin
			write_capacity(phase_caps[ph]);
			quiet_tail    = (ph == PHASES - 1);
			send_idle_pct = idle_choices[$urandom_range(0, 2)];
			recv_idle_pct = idle_choices[$urandom_range(0, 2)];
			eff = (phase_caps[ph] == 0) ? 1 :
				(int'(phase_caps[ph]) > MAX_ENTRIES) ? MAX_ENTRIES : int'(phase_caps[ph]);
			pool_size = eff + $urandom_range(0, 4);
			for (int i = 0; i < pool_size; i++)
				pool[i] = $urandom;
			items = quiet_tail ? TAIL_ITEMS : PHASE_ITEMS;
			for (int k = 0; k < items; k++) begin
				if (ph == 2 && k == PHASE_ITEMS / 2)
					drain_results();
				if (ph == 5 && k == 20)
					hold_requests++;
				if ($urandom_range(0, 99) < 85)
					pick = pool[$urandom_range(0, pool_size - 1)];
				else
					pick = $urandom;
				offer_page(pick);
			end
		end

		// Wind down: wait out every outstanding result before the verdict
		drain_results();
		repeat (8) @(negedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("lru_page_cache_tags_core verification clean");
		end else begin
			$display("lru_page_cache_tags_core verification failed");
		end
		$finish;
	end

endmodule

### files.f
hw/rtl/lpct_pkg.sv
hw/rtl/lpct_lookup.sv
hw/rtl/lru_page_cache_tags_core.sv
test/lru_page_cache_tags_core_checker.sv
test/lru_page_cache_tags_core_test.sv
